@@ sv/ttrp_pkg.sv @@
// types, constants and helpers shared by the timing record parser
`default_nettype none

package ttrp_pkg;

  // header byte layout
  localparam int unsigned HdrArrivalBit = 7;
  localparam int unsigned HdrClockBit   = 6;
  localparam logic [7:0]  HdrStepMask   = 8'h3f;

  // clock reference word layout
  localparam int unsigned ExtDiscBit   = 15;
  localparam logic [15:0] ExtPidMask   = 16'h7c00;
  localparam logic [15:0] ExtValueMask = 16'h03ff;

  // field lengths in bytes
  localparam logic [2:0] ArrivalBytes = 3'd4;
  localparam logic [2:0] EscapeBytes  = 3'd2;
  localparam logic [2:0] BaseBytes    = 3'd4;
  localparam logic [2:0] ExtWordBytes = 3'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ARRIVAL = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_BASE    = 3'd3,
    PH_EXTWORD = 3'd4,
    PH_PIDLOW  = 3'd5
  } ttrp_phase_e;

  typedef struct packed {
    logic [31:0] packet_index;
    logic [15:0] index_step;
    logic [31:0] arrival_stamp;
    logic        arrival_updated;
    logic        clock_present;
    logic [31:0] clock_base;
    logic [9:0]  clock_extension;
    logic        discontinuity;
    logic [12:0] stream_pid;
  } ttrp_result_t;

  // first section at or after from that the header asks for, header phase when done
  function automatic ttrp_phase_e pick_section(ttrp_phase_e from, logic [7:0] hdr);
    ttrp_phase_e res;
    if (from <= PH_ARRIVAL && hdr[HdrArrivalBit]) begin
      res = PH_ARRIVAL;
    end else if (from <= PH_ESCAPE && (hdr & HdrStepMask) == 8'h00) begin
      res = PH_ESCAPE;
    end else if (from <= PH_BASE && hdr[HdrClockBit]) begin
      res = PH_BASE;
    end else begin
      res = PH_HEADER;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/ttrp_parser.sv @@
// byte-wise record parser: field state machine, held fields and running index
`default_nettype none

module ttrp_parser
  import ttrp_pkg::*;
#(
  parameter int unsigned IndexWidth = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  output      logic         done_o,
  output      ttrp_result_t result_o
);

  ttrp_phase_e           phase_q, phase_d;
  logic [2:0]            count_q, count_d;
  logic [31:0]           shift_q, shift_d;
  logic [7:0]            header_q, header_d;
  logic [IndexWidth-1:0] index_q, index_d;
  logic [15:0]           inc_q, inc_d;
  logic [31:0]           arrival_q, arrival_d;
  logic [31:0]           base_q, base_d;
  logic [15:0]           extw_q, extw_d;

  logic [31:0] shift_nx;
  logic [2:0]  count_nx;
  logic        fin;
  logic [63:0] index_ext;

  assign shift_nx = {shift_q[23:0], byte_i};
  assign count_nx = count_q + 3'd1;

  // phase, byte counter and assembly shifter
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    shift_d = shift_q;
    fin     = 1'b0;
    if (step_i) begin
      count_d = count_nx;
      shift_d = shift_nx;
      case (phase_q)
        PH_HEADER: begin
          phase_d = pick_section(PH_ARRIVAL, byte_i);
          fin     = (phase_d == PH_HEADER);
          count_d = 3'd0;
          shift_d = 32'h0;
        end
        PH_ARRIVAL: begin
          if (count_nx >= ArrivalBytes) begin
            phase_d = pick_section(PH_ESCAPE, header_q);
            fin     = (phase_d == PH_HEADER);
            count_d = 3'd0;
            shift_d = 32'h0;
          end
        end
        PH_ESCAPE: begin
          if (count_nx >= EscapeBytes) begin
            phase_d = pick_section(PH_BASE, header_q);
            fin     = (phase_d == PH_HEADER);
            count_d = 3'd0;
            shift_d = 32'h0;
          end
        end
        PH_BASE: begin
          if (count_nx >= BaseBytes) begin
            phase_d = PH_EXTWORD;
            count_d = 3'd0;
            shift_d = 32'h0;
          end
        end
        PH_EXTWORD: begin
          if (count_nx >= ExtWordBytes) begin
            phase_d = PH_PIDLOW;
            count_d = 3'd0;
            shift_d = 32'h0;
          end
        end
        PH_PIDLOW: begin
          phase_d = PH_HEADER;
          fin     = 1'b1;
          count_d = 3'd0;
          shift_d = 32'h0;
        end
        default: begin
          phase_d = PH_HEADER;
          count_d = 3'd0;
          shift_d = 32'h0;
        end
      endcase
    end
  end

  // held fields, running index and the finished record
  always_comb begin
    header_d  = header_q;
    inc_d     = inc_q;
    arrival_d = arrival_q;
    base_d    = base_q;
    extw_d    = extw_q;
    if (step_i) begin
      case (phase_q)
        PH_HEADER: begin
          header_d = byte_i;
          inc_d    = {8'h00, byte_i & HdrStepMask};
        end
        PH_ARRIVAL: begin
          if (count_nx >= ArrivalBytes) begin
            arrival_d = shift_nx;
          end
        end
        PH_ESCAPE: begin
          if (count_nx >= EscapeBytes) begin
            inc_d = shift_nx[15:0];
          end
        end
        PH_BASE: begin
          if (count_nx >= BaseBytes) begin
            base_d = shift_nx;
          end
        end
        PH_EXTWORD: begin
          if (count_nx >= ExtWordBytes) begin
            extw_d = shift_nx[15:0];
          end
        end
        default: begin
        end
      endcase
    end

    index_d   = fin ? index_q + IndexWidth'(inc_d) : index_q;
    index_ext = 64'(index_d);

    result_o                 = '0;
    result_o.packet_index    = index_ext[31:0];
    result_o.index_step      = inc_d;
    result_o.arrival_stamp   = arrival_d;
    result_o.arrival_updated = header_d[HdrArrivalBit];
    result_o.clock_present   = header_d[HdrClockBit];
    if (header_d[HdrClockBit]) begin
      result_o.clock_base      = base_d;
      result_o.clock_extension = 10'(extw_d & ExtValueMask);
      result_o.discontinuity   = extw_d[ExtDiscBit];
      // pid low byte is the byte that closes the record
      result_o.stream_pid      = {5'((extw_d & ExtPidMask) >> 10), byte_i};
    end
  end

  assign done_o = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      count_q   <= 3'd0;
      shift_q   <= 32'h0;
      header_q  <= 8'h00;
      index_q   <= '0;
      inc_q     <= 16'h0;
      arrival_q <= 32'h0;
      base_q    <= 32'h0;
      extw_q    <= 16'h0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      shift_q   <= shift_d;
      header_q  <= header_d;
      index_q   <= index_d;
      inc_q     <= inc_d;
      arrival_q <= arrival_d;
      base_q    <= base_d;
      extw_q    <= extw_d;
    end
  end

  // no field is longer than four bytes, so the counter never reaches four between steps
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 3'd3)
    else $error("byte counter ran past the longest field");

  // the pid low byte only follows a completed clock reference word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_EXTWORD && count_nx >= ExtWordBytes |=> phase_q == PH_PIDLOW)
    else $error("clock reference word did not lead to pid low byte");

  // a record finishes only back in the header phase with the counter cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> phase_q == PH_HEADER && count_q == 3'd0 && shift_q == 32'h0)
    else $error("record finished without returning to header phase");

endmodule

`default_nettype wire

@@ sv/transport_time_record_parser.sv @@
// top level of the transport time record parser: input register, parser, result register
`default_nettype none

// Takes one byte of the timing record stream per request and returns one decoded record
// whenever a record completes (header, optional arrival time, optional escaped increment,
// optional clock reference). A new byte can be accepted every clock cycle; the bytes pass an
// input register and the parser state machine, and a finished record sits in a result
// register. A waiting record stalls the input only when the input register is full and the
// record in the result register is not taken in that cycle.
// INDEX_WIDTH sets the width of the running packet index; packet_index shows its low 32 bits.

module transport_time_record_parser
  import ttrp_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] packet_index_o,
  output      logic [15:0] index_step_o,
  output      logic [31:0] arrival_stamp_o,
  output      logic        arrival_updated_o,
  output      logic        clock_present_o,
  output      logic [31:0] clock_base_o,
  output      logic [9:0]  clock_extension_o,
  output      logic        discontinuity_o,
  output      logic [12:0] stream_pid_o
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q, in_byte_d;
  logic         out_valid_q, out_valid_d;
  ttrp_result_t out_q, out_d;

  logic         advance;
  logic         step;
  logic         done;
  ttrp_result_t result;

  // the parser moves whenever a byte is held and the result register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  ttrp_parser #(
    .IndexWidth(INDEX_WIDTH)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .done_o  (done),
    .result_o(result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      in_byte_d  = stream_byte_i;
    end
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = step && done;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign packet_index_o    = out_q.packet_index;
  assign index_step_o      = out_q.index_step;
  assign arrival_stamp_o   = out_q.arrival_stamp;
  assign arrival_updated_o = out_q.arrival_updated;
  assign clock_present_o   = out_q.clock_present;
  assign clock_base_o      = out_q.clock_base;
  assign clock_extension_o = out_q.clock_extension;
  assign discontinuity_o   = out_q.discontinuity;
  assign stream_pid_o      = out_q.stream_pid;

  // a finished record always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni) step && done |=> out_valid_q)
    else $error("finished record was not registered");

  // records without a clock reference carry zero clock fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.clock_present |->
      out_q.clock_base == 32'h0 && out_q.stream_pid == 13'h0 &&
      out_q.clock_extension == 10'h0 && !out_q.discontinuity)
    else $error("clock fields set on a record without clock reference");

  // the parser never steps while a stalled record still occupies the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !step)
    else $error("parser stepped over a stalled record");

endmodule

`default_nettype wire
